### rtl/core/cfsa_pkg.sv
// ----------------------------------------------------------------------------
// cfsa_pkg
// Shared types, constants and helpers for the CAN frame to SLCAN ASCII encoder.
// ----------------------------------------------------------------------------
package cfsa_pkg;

    localparam int MAX_DATA_BYTES = 8;

    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_STD_DATA = 8'h74;  // 't'
    localparam logic [7:0] CHAR_STD_RTR  = 8'h72;  // 'r'
    localparam logic [7:0] CHAR_EXT_DATA = 8'h54;  // 'T'
    localparam logic [7:0] CHAR_EXT_RTR  = 8'h52;  // 'R'

    typedef struct packed {
        logic        is_extended;
        logic        is_remote;
        logic [28:0] identifier;
        logic [3:0]  length_code;
        logic [63:0] payload;
    } frame_t;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic       is_last;
    } char_t;

    // Classified frame: identifier nibbles left-aligned, length clamped
    typedef struct packed {
        logic        is_extended;
        logic        is_remote;
        logic [31:0] id_nibbles;
        logic [3:0]  data_len;
        logic [63:0] payload;
    } cmd_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
        logic [7:0] n;
        n = {4'b0000, nibble};
        return (nibble < 4'd10) ? n + 8'd48 : n + 8'd55;
    endfunction

endpackage

### rtl/core/cfsa_front.sv
// ----------------------------------------------------------------------------
// cfsa_front
// Accepts frames and classifies them into encoder commands.
// ----------------------------------------------------------------------------
module cfsa_front
(
    input  logic             push,
    output logic             full,
    input  cfsa_pkg::frame_t frame,
    input  logic             queue_full,
    output logic             wr_en,
    output cfsa_pkg::cmd_t   wr_data
);

    logic [3:0] len_clamped;

    assign full  = queue_full;
    assign wr_en = push && !queue_full;

    assign len_clamped = (frame.length_code > 4'(cfsa_pkg::MAX_DATA_BYTES)) ?
                         4'(cfsa_pkg::MAX_DATA_BYTES) : frame.length_code;

    always_comb
    begin
        wr_data.is_extended = frame.is_extended;
        wr_data.is_remote   = frame.is_remote;
        wr_data.data_len    = len_clamped;
        wr_data.payload     = frame.payload;
        if (frame.is_extended)
        begin
            wr_data.id_nibbles = {3'b000, frame.identifier};
        end
        else
        begin
            // standard id: low 11 bits shifted right by one, three digits
            wr_data.id_nibbles = {2'b00, frame.identifier[10:1], 20'h00000};
        end
    end

endmodule

### rtl/core/cfsa_queue.sv
// ----------------------------------------------------------------------------
// cfsa_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module cfsa_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  cfsa_pkg::cmd_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output cfsa_pkg::cmd_t rd_data,
    output logic           empty
);

    cfsa_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/core/cfsa_back.sv
// ----------------------------------------------------------------------------
// cfsa_back
// Serializes one command into SLCAN characters through an output register.
// ----------------------------------------------------------------------------
module cfsa_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_empty,
    input  cfsa_pkg::cmd_t  cmd,
    output logic            cmd_pop,
    output logic            empty,
    input  logic            pop,
    output cfsa_pkg::char_t result
);

    localparam logic [2:0] PH_TYPE = 3'd0;
    localparam logic [2:0] PH_ID   = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CR   = 3'd4;

    logic            busy_reg,  busy_next;
    logic [2:0]      phase_reg, phase_next;
    logic [3:0]      cnt_reg,   cnt_next;
    logic            ext_reg;
    logic            rem_reg;
    logic [3:0]      len_reg;
    logic [31:0]     id_reg,    id_next;
    logic [63:0]     data_reg,  data_next;
    logic            out_valid_reg;
    cfsa_pkg::char_t char_reg;
    cfsa_pkg::char_t char_next;
    logic            step;
    logic            load;
    logic [4:0]      nibbles;

    assign step    = busy_reg && (!out_valid_reg || pop);
    assign load    = !cmd_empty && (!busy_reg || (step && phase_reg == PH_CR));
    assign cmd_pop = load;
    assign empty   = !out_valid_reg;
    assign result  = char_reg;
    assign nibbles = {len_reg, 1'b0} - 5'd1;

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        id_next    = id_reg;
        data_next  = data_reg;
        char_next  = '{ascii_char: cfsa_pkg::CHAR_CR, is_last: 1'b0};
        case (phase_reg)
            PH_TYPE:
            begin
                if (ext_reg)
                begin
                    char_next.ascii_char = rem_reg ? cfsa_pkg::CHAR_EXT_RTR :
                                                     cfsa_pkg::CHAR_EXT_DATA;
                    cnt_next = 4'd7;
                end
                else
                begin
                    char_next.ascii_char = rem_reg ? cfsa_pkg::CHAR_STD_RTR :
                                                     cfsa_pkg::CHAR_STD_DATA;
                    cnt_next = 4'd2;
                end
                phase_next = PH_ID;
            end
            PH_ID:
            begin
                char_next.ascii_char = cfsa_pkg::hex_digit(id_reg[31:28]);
                id_next = {id_reg[27:0], 4'h0};
                if (cnt_reg == 4'd0)
                begin
                    phase_next = PH_LEN;
                end
                else
                begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            PH_LEN:
            begin
                char_next.ascii_char = cfsa_pkg::CHAR_ZERO + {4'h0, len_reg};
                if (rem_reg || len_reg == 4'd0)
                begin
                    phase_next = PH_CR;
                end
                else
                begin
                    phase_next = PH_DATA;
                    cnt_next   = nibbles[3:0];
                end
            end
            PH_DATA:
            begin
                if (cnt_reg[0])
                begin
                    char_next.ascii_char = cfsa_pkg::hex_digit(data_reg[7:4]);
                end
                else
                begin
                    char_next.ascii_char = cfsa_pkg::hex_digit(data_reg[3:0]);
                    data_next = {8'h00, data_reg[63:8]};
                end
                if (cnt_reg == 4'd0)
                begin
                    phase_next = PH_CR;
                end
                else
                begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            PH_CR:
            begin
                char_next.ascii_char = cfsa_pkg::CHAR_CR;
                char_next.is_last    = 1'b1;
                busy_next            = 1'b0;
                phase_next           = PH_TYPE;
            end
            default:
            begin
                busy_next  = 1'b0;
                phase_next = PH_TYPE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_TYPE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= PH_TYPE;
            end
            else if (step)
            begin
                busy_reg  <= busy_next;
                phase_reg <= phase_next;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            char_reg <= char_next;
        end
        if (load)
        begin
            ext_reg  <= cmd.is_extended;
            rem_reg  <= cmd.is_remote;
            len_reg  <= cmd.data_len;
            id_reg   <= cmd.id_nibbles;
            data_reg <= cmd.payload;
            cnt_reg  <= 4'd0;
        end
        else if (step)
        begin
            id_reg   <= id_next;
            data_reg <= data_next;
            cnt_reg  <= cnt_next;
        end
    end

    a_last_is_cr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && char_reg.is_last |-> char_reg.ascii_char == cfsa_pkg::CHAR_CR)
        else $error("last flag on a character other than CR");

    a_cr_step_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_CR |=> out_valid_reg && char_reg.is_last)
        else $error("CR step did not produce a last character");

    a_load_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> busy_reg && phase_reg == PH_TYPE)
        else $error("command load did not start at the type character");

    a_id_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && phase_reg == PH_ID |-> cnt_reg <= 4'd7)
        else $error("identifier digit count out of range");

endmodule

### rtl/core/can_frame_to_slcan_ascii.sv
// ----------------------------------------------------------------------------
// can_frame_to_slcan_ascii
// Encodes received CAN frames into SLCAN text lines, one character per transfer.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  frame     in         push / full      cfsa_pkg::frame_t
//  result    out        pop / empty      cfsa_pkg::char_t
//
//  A frame yields 6 to 27 characters from the back serializer, one per cycle
//  while pop stays high. Frames follow back to back; a two-entry command queue
//  lets the front accept up to two frames ahead of the serializer.
//  Reset clears the queue, the serializer and the output register.
//  A held result (pop low) stalls the serializer; full rises when the queue fills.
// ----------------------------------------------------------------------------
module can_frame_to_slcan_ascii
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  cfsa_pkg::frame_t frame,
    output logic             empty,
    input  logic             pop,
    output cfsa_pkg::char_t  result
);

    logic           q_wr_en;
    cfsa_pkg::cmd_t q_wr_data;
    logic           q_full;
    logic           q_rd_en;
    cfsa_pkg::cmd_t q_rd_data;
    logic           q_empty;

    cfsa_front u_front
    (
        .push       (push),
        .full       (full),
        .frame      (frame),
        .queue_full (q_full),
        .wr_en      (q_wr_en),
        .wr_data    (q_wr_data)
    );

    cfsa_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    cfsa_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (q_empty),
        .cmd       (q_rd_data),
        .cmd_pop   (q_rd_en),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

### dv/slcan_line_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slcan_line_checker
// Watches the frame and character channels of the SLCAN encoder. Each accepted
// frame is expanded into the character line it should produce. Each accepted
// character is compared with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module slcan_line_checker
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             full,
    input  cfsa_pkg::frame_t frame,
    input  logic             empty,
    input  logic             pop,
    input  cfsa_pkg::char_t  result,
    output int               failures,
    output int               pending
);

    cfsa_pkg::char_t expected_chars[$];

    function automatic logic [7:0] nibble_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib <= 4'd9)
            ch = "0" + nib;
        else
            ch = "A" + (nib - 4'd10);
        return ch;
    endfunction

    function automatic void add_char(input logic [7:0] ch, input logic last);
        cfsa_pkg::char_t c;
        c.ascii_char = ch;
        c.is_last    = last;
        expected_chars.push_back(c);
    endfunction

    function automatic void predict_line(input cfsa_pkg::frame_t f);
        logic [31:0] ext_id;
        logic [11:0] std_id;
        logic [3:0]  n_bytes;
        logic [7:0]  data_byte;
        if (f.is_extended)
        begin
            ext_id = {3'b000, f.identifier};
            add_char(f.is_remote ? cfsa_pkg::CHAR_EXT_RTR : cfsa_pkg::CHAR_EXT_DATA, 1'b0);
            for (int i = 7; i >= 0; i--)
                add_char(nibble_char(ext_id[i*4 +: 4]), 1'b0);
        end
        else
        begin
            std_id = {2'b00, f.identifier[10:1]};
            add_char(f.is_remote ? cfsa_pkg::CHAR_STD_RTR : cfsa_pkg::CHAR_STD_DATA, 1'b0);
            for (int i = 2; i >= 0; i--)
                add_char(nibble_char(std_id[i*4 +: 4]), 1'b0);
        end
        n_bytes = (f.length_code > cfsa_pkg::MAX_DATA_BYTES) ?
                  4'(cfsa_pkg::MAX_DATA_BYTES) : f.length_code;
        add_char(cfsa_pkg::CHAR_ZERO + n_bytes, 1'b0);
        if (!f.is_remote)
        begin
            for (int i = 0; i < n_bytes; i++)
            begin
                data_byte = f.payload[i*8 +: 8];
                add_char(nibble_char(data_byte[7:4]), 1'b0);
                add_char(nibble_char(data_byte[3:0]), 1'b0);
            end
        end
        add_char(cfsa_pkg::CHAR_CR, 1'b1);
    endfunction

    always @(posedge clk)
    begin
        cfsa_pkg::char_t want;
        int              errs;
        errs = 0;
        if (!rst_n)
        begin
            failures <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected character transfer: %h last=%b",
                           result.ascii_char, result.is_last);
                    errs = errs + 1;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (result.ascii_char !== want.ascii_char)
                    begin
                        $error("ascii_char mismatch: expected %h, actual %h",
                               want.ascii_char, result.ascii_char);
                        errs = errs + 1;
                    end
                    if (result.is_last !== want.is_last)
                    begin
                        $error("is_last mismatch: expected %b, actual %b",
                               want.is_last, result.is_last);
                        errs = errs + 1;
                    end
                end
            end
            if (push && !full)
                predict_line(frame);
            failures <= failures + errs;
        end
        pending <= expected_chars.size();
    end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Top of the SLCAN encoder bench. Drives directed and random CAN frames with
// random idle bursts on both channels, drains fully after the directed frames
// and at the end, then judges by the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_FRAMES = 106;
    localparam int QUIET_FRAMES  = 20;
    localparam int CYCLE_LIMIT   = 200000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             push;
    logic             full;
    cfsa_pkg::frame_t frame;
    logic             empty;
    logic             pop = 1'b0;
    cfsa_pkg::char_t  result;

    int     failures;
    int     pending;
    int     cycles = 0;
    bit     quiet = 1'b0;
    int     pop_hold = 0;

    can_frame_to_slcan_ascii DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .frame  (frame),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    slcan_line_checker checker_i
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .frame    (frame),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .failures (failures),
        .pending  (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stall bursts, none in the quiet tail
    always @(posedge clk)
    begin
        if (pop_hold > 0)
        begin
            pop_hold <= pop_hold - 1;
            pop      <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            pop_hold <= int'($urandom_range(0, 8));
            pop      <= 1'b0;
        end
        else
            pop <= rst_n;
    end

    function automatic cfsa_pkg::frame_t make_frame(input logic ext, input logic rem,
                                                    input logic [28:0] id,
                                                    input logic [3:0] len,
                                                    input logic [63:0] data);
        cfsa_pkg::frame_t f;
        f.is_extended = ext;
        f.is_remote   = rem;
        f.identifier  = id;
        f.length_code = len;
        f.payload     = data;
        return f;
    endfunction

    task automatic send_frame(input cfsa_pkg::frame_t f);
        push  <= 1'b1;
        frame <= f;
        do
            @(posedge clk);
        while (full);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic drain_lines();
        push <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        logic        ext;
        logic        rem;
        logic [28:0] id;
        logic [3:0]  len;
        logic [63:0] data;

        rst_n = 1'b0;
        push  = 1'b0;
        frame = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_frame(make_frame(1'b0, 1'b0, 29'h0,        4'd0,  64'h0));
        send_frame(make_frame(1'b0, 1'b0, 29'h7FF,      4'd8,  64'h0));
        send_frame(make_frame(1'b0, 1'b0, 29'h1FFFFFFF, 4'd8,  '1));
        send_frame(make_frame(1'b1, 1'b0, 29'h1FFFFFFF, 4'd8,  64'h0123456789ABCDEF));
        send_frame(make_frame(1'b1, 1'b0, 29'h0,        4'd8,  64'hFEDCBA9876543210));
        send_frame(make_frame(1'b1, 1'b1, 29'h12345678, 4'd4,  '1));
        send_frame(make_frame(1'b0, 1'b1, 29'h555,      4'd15, '1));
        send_frame(make_frame(1'b0, 1'b0, 29'h2AA,      4'd9,  64'hA5A5A5A5A5A5A5A5));
        send_frame(make_frame(1'b1, 1'b0, 29'h0ABCDEF0, 4'd15, 64'h5A5A5A5A5A5A5A5A));
        send_frame(make_frame(1'b1, 1'b1, 29'h0ABCDEF0, 4'd0,  64'h0));
        send_frame(make_frame(1'b0, 1'b1, 29'h0,        4'd0,  64'h0));
        send_frame(make_frame(1'b0, 1'b0, 29'h001,      4'd1,  64'h9F));
        send_frame(make_frame(1'b1, 1'b0, 29'h10000000, 4'd1,  64'hC3));
        send_frame(make_frame(1'b0, 1'b0, 29'h1FFFF7FE, 4'd7,  64'h00FF00FF00FF00FF));

        drain_lines();

        for (int n = 0; n < RANDOM_FRAMES; n++)
        begin
            if (n == RANDOM_FRAMES - QUIET_FRAMES)
                quiet = 1'b1;
            ext  = 1'($urandom_range(0, 1));
            rem  = ($urandom_range(0, 3) == 0);
            id   = 29'($urandom);
            len  = 4'($urandom_range(0, 15));
            data = {$urandom, $urandom};
            send_frame(make_frame(ext, rem, id, len, data));
        end

        drain_lines();
        repeat (40) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/core/cfsa_pkg.sv
rtl/core/cfsa_front.sv
rtl/core/cfsa_queue.sv
rtl/core/cfsa_back.sv
rtl/core/can_frame_to_slcan_ascii.sv
dv/slcan_line_checker.sv
dv/tb.sv
